// ----- rtl/ldf_pkg.sv -----
package ldf_pkg;

	localparam int BYTE_W              = 8;
	localparam int INDEX_W             = 6;
	localparam int DEF_MAX_ENTRIES     = 64;
	localparam int DEF_MAX_LINE_LENGTH = 128;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic kept;
		logic absorbed;
		logic found;
	} beat_ctl_t;

endpackage

// ----- rtl/ldf_line_if.sv -----
interface ldf_line_if import ldf_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] line_byte;
	logic              line_end;

	modport source(output valid, line_byte, line_end, input ready);
	modport sink(input valid, line_byte, line_end, output ready);
endinterface

// ----- rtl/ldf_result_if.sv -----
interface ldf_result_if import ldf_pkg::*;;
	logic               valid;
	logic               ready;
	logic               is_first;
	logic [INDEX_W-1:0] entry_index;
	logic               table_full;

	modport source(output valid, is_first, entry_index, table_full, input ready);
	modport sink(input valid, is_first, entry_index, table_full, output ready);
endinterface

// ----- rtl/ldf_front.sv -----
module ldf_front import ldf_pkg::*; #(
	parameter  int MAX_LINE_LENGTH = DEF_MAX_LINE_LENGTH,
	parameter  int MAX_ENTRIES     = DEF_MAX_ENTRIES,
	localparam int PW              = $clog2(MAX_LINE_LENGTH),
	localparam int LW              = $clog2(MAX_LINE_LENGTH + 1),
	localparam int IW              = $clog2(MAX_ENTRIES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              in_end,
	output beat_ctl_t         ctl,
	output logic [BYTE_W-1:0] byte_o,
	output logic [PW-1:0]     pos,
	output logic [LW-1:0]     len,
	output logic [IW-1:0]     idx
);

	logic [LW-1:0] cnt_q;
	logic          kept;

	// position within the current line, saturates at the maximum length
	assign kept = cnt_q < LW'(MAX_LINE_LENGTH);

	always_comb begin
		ctl          = '0;
		ctl.valid    = in_valid && (kept || in_end);
		ctl.first    = cnt_q == '0;
		ctl.last     = in_end;
		ctl.kept     = kept;
		ctl.absorbed = 1'b0;
		ctl.found    = 1'b0;
		byte_o       = in_byte;
		pos          = cnt_q[PW-1:0];
		len          = kept ? cnt_q + LW'(1) : cnt_q;
		idx          = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (adv && in_valid) begin
			if (in_end) begin
				cnt_q <= '0;
			end else if (kept) begin
				cnt_q <= cnt_q + LW'(1);
			end
		end
	end

endmodule

// ----- rtl/ldf_cell.sv -----
module ldf_cell import ldf_pkg::*; #(
	parameter  int MAX_LINE_LENGTH = DEF_MAX_LINE_LENGTH,
	parameter  int MAX_ENTRIES     = DEF_MAX_ENTRIES,
	parameter  int CELL_ID         = 0,
	localparam int PW              = $clog2(MAX_LINE_LENGTH),
	localparam int LW              = $clog2(MAX_LINE_LENGTH + 1),
	localparam int IW              = $clog2(MAX_ENTRIES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  beat_ctl_t         ctl_in,
	input  logic [BYTE_W-1:0] byte_in,
	input  logic [PW-1:0]     pos_in,
	input  logic [LW-1:0]     len_in,
	input  logic [IW-1:0]     idx_in,
	output beat_ctl_t         ctl_out,
	output logic [BYTE_W-1:0] byte_out,
	output logic [PW-1:0]     pos_out,
	output logic [LW-1:0]     len_out,
	output logic [IW-1:0]     idx_out
);

	logic [BYTE_W-1:0] mem [MAX_LINE_LENGTH];

	beat_ctl_t         ctl_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [PW-1:0]     pos_s1;
	logic [LW-1:0]     len_s1;
	logic [IW-1:0]     idx_s1;
	logic [BYTE_W-1:0] rd_q;
	logic              match_q;
	logic              filled_q;
	logic [LW-1:0]     slen_q;

	logic cur_match;
	logic hit;
	logic commit;
	logic filled_now;
	logic wr_en;

	always_comb begin
		cur_match = (ctl_s1.kept ? (rd_q == byte_s1) : 1'b1) && (ctl_s1.first || match_q);
		hit       = ctl_s1.valid && ctl_s1.last && filled_q && cur_match && (slen_q == len_s1);
		commit    = ctl_s1.valid && ctl_s1.last && !filled_q && !ctl_s1.absorbed
			&& !ctl_s1.found;
		// a line closing here claims the slot before the next beat can write it
		filled_now = filled_q || commit;
		wr_en      = ctl_in.valid && ctl_in.kept && !filled_now && !ctl_in.absorbed;

		ctl_out          = ctl_s1;
		ctl_out.absorbed = ctl_s1.absorbed || !filled_q;
		ctl_out.found    = ctl_s1.found || hit;
		byte_out         = byte_s1;
		pos_out          = pos_s1;
		len_out          = len_s1;
		idx_out          = ((hit && !ctl_s1.found) || commit) ? IW'(CELL_ID) : idx_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (wr_en) begin
				mem[pos_in] <= byte_in;
			end
			rd_q <= mem[pos_in];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_s1 <= byte_in;
			pos_s1  <= pos_in;
			len_s1  <= len_in;
			idx_s1  <= idx_in;
			if (commit) begin
				slen_q <= len_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			match_q  <= 1'b0;
			filled_q <= 1'b0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
			if (ctl_s1.valid) begin
				match_q <= cur_match;
			end
			if (commit) begin
				filled_q <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/line_dedup_filter.sv -----
// Duplicate line filter. Lines arrive one byte per beat on lines, the last byte marked by
// line_end; bytes past MAX_LINE_LENGTH are dropped but line_end still closes the line. One
// verdict beat per line: is_first with the new slot, a repeat with the slot of its first
// copy, or table_full when no slot is free. The table is a chain of MAX_ENTRIES cells, one
// slot each with its own line memory; every byte walks the chain one cell per cycle while the
// input is not stalled, so a byte is taken every such cycle; a verdict is registered
// when its line's last byte leaves the last cell. Input stalls only while a verdict waits in
// the output register. The stored table needs no clearing after reset.
module line_dedup_filter import ldf_pkg::*; #(
	parameter  int MAX_ENTRIES     = DEF_MAX_ENTRIES,
	parameter  int MAX_LINE_LENGTH = DEF_MAX_LINE_LENGTH,
	localparam int PW              = $clog2(MAX_LINE_LENGTH),
	localparam int LW              = $clog2(MAX_LINE_LENGTH + 1),
	localparam int IW              = $clog2(MAX_ENTRIES)
) (
	input  logic          clk,
	input  logic          arst_n,
	ldf_line_if.sink      lines,
	ldf_result_if.source  verdict
);

	beat_ctl_t         ctl_c  [MAX_ENTRIES+1];
	logic [BYTE_W-1:0] byte_c [MAX_ENTRIES+1];
	logic [PW-1:0]     pos_c  [MAX_ENTRIES+1];
	logic [LW-1:0]     len_c  [MAX_ENTRIES+1];
	logic [IW-1:0]     idx_c  [MAX_ENTRIES+1];

	logic               adv;
	logic               res_valid_q;
	logic               is_first_q;
	logic [INDEX_W-1:0] index_q;
	logic               full_q;
	beat_ctl_t          tail;

	assign adv         = !res_valid_q || verdict.ready;
	assign lines.ready = adv;

	ldf_front #(
		.MAX_LINE_LENGTH(MAX_LINE_LENGTH),
		.MAX_ENTRIES    (MAX_ENTRIES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_valid(lines.valid),
		.in_byte (lines.line_byte),
		.in_end  (lines.line_end),
		.ctl     (ctl_c[0]),
		.byte_o  (byte_c[0]),
		.pos     (pos_c[0]),
		.len     (len_c[0]),
		.idx     (idx_c[0])
	);

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		ldf_cell #(
			.MAX_LINE_LENGTH(MAX_LINE_LENGTH),
			.MAX_ENTRIES    (MAX_ENTRIES),
			.CELL_ID        (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.ctl_in  (ctl_c[g]),
			.byte_in (byte_c[g]),
			.pos_in  (pos_c[g]),
			.len_in  (len_c[g]),
			.idx_in  (idx_c[g]),
			.ctl_out (ctl_c[g+1]),
			.byte_out(byte_c[g+1]),
			.pos_out (pos_c[g+1]),
			.len_out (len_c[g+1]),
			.idx_out (idx_c[g+1])
		);
	end

	assign tail = ctl_c[MAX_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= tail.valid && tail.last;
		end
	end

	// found wins; otherwise an empty slot took the line, or the table is full
	always_ff @(posedge clk) begin
		if (adv) begin
			is_first_q <= !tail.found && tail.absorbed;
			full_q     <= !tail.found && !tail.absorbed;
			index_q    <= (tail.found || tail.absorbed) ? INDEX_W'(idx_c[MAX_ENTRIES]) : '0;
		end
	end

	assign verdict.valid       = res_valid_q;
	assign verdict.is_first    = is_first_q;
	assign verdict.entry_index = index_q;
	assign verdict.table_full  = full_q;

endmodule

// ----- sim/tb.sv -----
module tb;
	import ldf_pkg::*;

	localparam int N_SLOTS     = DEF_MAX_ENTRIES;
	localparam int LINE_MAX    = DEF_MAX_LINE_LENGTH;
	localparam int POOL_MAX    = 400;
	localparam int SHORT_MAX   = 8;
	localparam int RANDOM_BEATS = 1000;
	localparam int CALM_BEATS  = 850;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 3000;

	typedef struct packed {
		logic               is_first;
		logic [INDEX_W-1:0] entry_index;
		logic               table_full;
	} verdict_t;

	class dedup_scoreboard;
		logic [BYTE_W-1:0] line_text [LINE_MAX];
		int                line_len;
		logic [BYTE_W-1:0] slot_text [N_SLOTS][LINE_MAX];
		int                slot_len [N_SLOTS];
		int                slots_used;
		verdict_t          verdicts_due[$];
		int                errors;

		function new();
			line_len   = 0;
			slots_used = 0;
			errors     = 0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function void take_byte(logic [BYTE_W-1:0] b, logic e);
			verdict_t v;
			int       hit;
			bit       same;
			if (line_len < LINE_MAX) begin
				line_text[line_len] = b;
				line_len++;
			end
			if (!e)
				return;
			hit = -1;
			for (int s = 0; s < slots_used && hit < 0; s++) begin
				same = (slot_len[s] == line_len);
				for (int k = 0; k < line_len && same; k++)
					if (slot_text[s][k] != line_text[k])
						same = 1'b0;
				if (same)
					hit = s;
			end
			v = '0;
			if (hit >= 0) begin
				v.entry_index = hit[INDEX_W-1:0];
			end else if (slots_used < N_SLOTS) begin
				for (int k = 0; k < line_len; k++)
					slot_text[slots_used][k] = line_text[k];
				slot_len[slots_used] = line_len;
				v.is_first           = 1'b1;
				v.entry_index        = slots_used[INDEX_W-1:0];
				slots_used++;
			end else begin
				v.table_full = 1'b1;
			end
			verdicts_due.push_back(v);
			line_len = 0;
		endfunction

		task match_verdict(logic first, logic [INDEX_W-1:0] idx, logic full);
			verdict_t want;
			if (verdicts_due.size() == 0) begin
				report($sformatf("verdict with none due: first=%0b index=%0d full=%0b",
					first, idx, full));
				return;
			end
			want = verdicts_due.pop_front();
			if (first !== want.is_first)
				report($sformatf("is_first %0b, want %0b", first, want.is_first));
			if (idx !== want.entry_index)
				report($sformatf("entry_index %0d, want %0d", idx, want.entry_index));
			if (full !== want.table_full)
				report($sformatf("table_full %0b, want %0b", full, want.table_full));
		endtask

		function int pending();
			return verdicts_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ldf_line_if   line_ch ();
	ldf_result_if verdict_ch ();

	line_dedup_filter #(
		.MAX_ENTRIES(N_SLOTS),
		.MAX_LINE_LENGTH(LINE_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.lines(line_ch),
		.verdict(verdict_ch)
	);

	dedup_scoreboard dedup = new();

	bit calm;
	bit hold_request;
	int beats_sent;

	logic [BYTE_W-1:0] text_buf [LINE_MAX + SHORT_MAX];
	int                text_len;
	logic [BYTE_W-1:0] pool_text [POOL_MAX][SHORT_MAX];
	int                pool_len [POOL_MAX];
	int                pool_count;
	logic [BYTE_W-1:0] long_base [LINE_MAX];
	int                long_count;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// one beat; every call starts and ends on a rising edge
	task automatic send_beat(input logic [BYTE_W-1:0] b, input logic e);
		int gap;
		if (!calm && $urandom_range(0, 11) == 0) begin
			gap = $urandom_range(1, 18);
			line_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		line_ch.valid     <= 1'b1;
		line_ch.line_byte <= b;
		line_ch.line_end  <= e;
		@(posedge clk);
		while (!line_ch.ready)
			@(posedge clk);
		dedup.take_byte(b, e);
		beats_sent++;
	endtask

	function automatic void add(input logic [BYTE_W-1:0] b);
		text_buf[text_len] = b;
		text_len++;
	endfunction

	task automatic send_text();
		for (int k = 0; k < text_len; k++)
			send_beat(text_buf[k], k == text_len - 1);
		text_len = 0;
	endtask

	task automatic wait_drained();
		line_ch.valid <= 1'b0;
		while (dedup.pending() != 0)
			@(posedge clk);
	endtask

	// exact, one byte short, or overlong by a few bytes
	task automatic long_line(input int variant);
		int n;
		n = (variant == 1) ? LINE_MAX - 1 : LINE_MAX;
		for (int k = 0; k < n; k++)
			add(long_base[k]);
		if (variant == 2) begin
			n = $urandom_range(1, SHORT_MAX - 2);
			for (int k = 0; k < n; k++)
				add(BYTE_W'($urandom_range(0, 255)));
		end
		long_count++;
		send_text();
	endtask

	task automatic random_line();
		int pick;
		int p;
		int n;
		bit narrow;
		pick = $urandom_range(0, 99);
		if (pick < 1 && long_count < 6) begin
			long_line($urandom_range(0, 2));
		end else if (pick < 46 && pool_count > 0) begin
			p = $urandom_range(0, pool_count - 1);
			for (int k = 0; k < pool_len[p]; k++)
				add(pool_text[p][k]);
			send_text();
		end else begin
			n      = $urandom_range(1, SHORT_MAX);
			narrow = 1'($urandom_range(0, 1));
			for (int k = 0; k < n; k++) begin
				if (narrow)
					add(BYTE_W'($urandom_range(0, 3) == 0 ? 8'hFF
						: 8'h41 + $urandom_range(0, 1)));
				else
					add(BYTE_W'($urandom_range(0, 255)));
			end
			if (pool_count < POOL_MAX) begin
				for (int k = 0; k < n; k++)
					pool_text[pool_count][k] = text_buf[k];
				pool_len[pool_count] = n;
				pool_count++;
			end
			send_text();
		end
	endtask

	initial begin : receiver
		int n;
		verdict_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				verdict_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_request = 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				verdict_ch.ready <= 1'b0;
				n = $urandom_range(1, 18);
				repeat (n - 1) @(posedge clk);
			end else begin
				verdict_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && verdict_ch.valid && verdict_ch.ready)
			dedup.match_verdict(verdict_ch.is_first, verdict_ch.entry_index,
				verdict_ch.table_full);
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((line_ch.valid && line_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("[line_dedup_filter] ERROR");
		$finish;
	end

	initial begin : stimulus
		int line_no;
		arst_n            <= 1'b0;
		line_ch.valid     <= 1'b0;
		line_ch.line_byte <= '0;
		line_ch.line_end  <= 1'b0;
		calm         = 1'b0;
		hold_request = 1'b0;
		beats_sent   = 0;
		text_len     = 0;
		pool_count   = 0;
		long_count   = 0;
		for (int k = 0; k < LINE_MAX; k++)
			long_base[k] = BYTE_W'($urandom_range(0, 255));
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single bytes at the extremes, length decides, prefixes and last-byte differences
		add(8'h00); send_text();
		add(8'hFF); send_text();
		add(8'h00); send_text();
		add(8'h00); add(8'h00); send_text();
		add(8'hFF); send_text();
		add(8'hA5); add(8'h5A); add(8'h0F); send_text();
		add(8'hA5); add(8'h5A); add(8'hF0); send_text();
		add(8'hA5); add(8'h5A); send_text();
		add(8'hA5); add(8'h5A); add(8'h0F); send_text();
		add(8'h80); add(8'h01); send_text();
		add(8'h7F); add(8'hFE); send_text();
		add(8'h00); add(8'h00); send_text();
		wait_drained();

		line_no = 0;
		while (beats_sent < RANDOM_BEATS) begin
			calm = (beats_sent > CALM_BEATS);
			if (line_no == 30)
				hold_request = 1'b1;
			if (line_no == 90)
				wait_drained();
			if (line_no == 10)
				long_line(0);
			else if (line_no == 11)
				long_line(2);
			else if (line_no == 12)
				long_line(1);
			else
				random_line();
			line_no++;
		end

		line_ch.valid <= 1'b0;
		while (dedup.pending() != 0)
			@(posedge clk);
		repeat (N_SLOTS + 16) @(posedge clk);
		if (dedup.errors == 0)
			$display("[line_dedup_filter] OK");
		else
			$display("[line_dedup_filter] ERROR");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/ldf_pkg.sv
rtl/ldf_line_if.sv
rtl/ldf_result_if.sv
rtl/ldf_front.sv
rtl/ldf_cell.sv
rtl/line_dedup_filter.sv
sim/tb.sv
